>>> src/biquad_pkg.sv
// Shared types and constants for the biquad IIR filter bank.
`default_nettype none

package biquad_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_BITS    = 16;
  localparam int COEFF_BITS     = 16;
  localparam int TYPES_PER_SIDE = 3;
  localparam int NUM_REGS       = 6;

  // Accumulator holds five full products without overflow
  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + 3;

  // History entry: {y2, y1, x2, x1}
  localparam int HIST_W = 4 * SAMPLE_BITS;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int NUM_W      = 3 * COEFF_BITS;
  localparam int DEN_W      = 2 * COEFF_BITS;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LP_NUM  = 3'd0,
    REG_LP_DEN  = 3'd1,
    REG_HPL_NUM = 3'd2,
    REG_HPL_DEN = 3'd3,
    REG_HPH_NUM = 3'd4,
    REG_HPH_DEN = 3'd5
  } reg_idx_t;

  // Filter type codes
  typedef enum logic [1:0] {
    FT_LOWPASS = 2'd0,
    FT_HP_LOW  = 2'd1,
    FT_HP_HIGH = 2'd2,
    FT_UNUSED  = 2'd3
  } filter_type_t;

  // Coefficient reset values (design coefficients rounded to Q2.14)
  localparam logic [NUM_W-1:0] LP_NUM_RST  = 48'd17983576871003;
  localparam logic [DEN_W-1:0] LP_DEN_RST  = 32'd188741166;
  localparam logic [NUM_W-1:0] HPL_NUM_RST = 48'd53277443436660;
  localparam logic [DEN_W-1:0] HPL_DEN_RST = 32'd616407790;
  localparam logic [NUM_W-1:0] HPH_NUM_RST = 48'd44112262998046;
  localparam logic [DEN_W-1:0] HPH_DEN_RST = 32'd427538690;

endpackage

`default_nettype wire

>>> src/biquad_iir_filter_bank_core.sv
// Top level of the biquad IIR filter bank: history memory and multiply-accumulate pipeline.
//
// Bank of direct-form-I biquads, two sides by three filter types.
// Input channel: in_tuser selects the instance (side, filter_type), in_tdata
// carries a signed Q1.15 sample. Each accepted item gives exactly one result
// on the out_ channel: the filtered, rounded and saturated Q1.15 sample.
// Items with filter type 3 give a zero result and leave all history as is.
// Each result passes through the stage 1, stage 2 and output registers.
// Throughput: one item per cycle while the pipeline is not held; an item for the same
// instance as the item still in stage 1 is held back, because its y1 comes out of the
// add/round/saturate stage that the earlier item has not yet reached.
// History lives in a one-port-read, one-port-write memory with a registered read; a
// same-instance item accepted while the earlier item writes back takes the new history
// from a bypass register. Reset clears all history (per-entry valid bits) and loads the
// default coefficients. Coefficients are written through the cfg_ port by the user, only
// while idle; the block itself does not enforce it. While a result waits and out_tready
// is low, the whole pipeline holds and in_tready drops.
`default_nettype none

module biquad_iir_filter_bank_core
  import biquad_pkg::*;
#(
  parameter int NUM_INSTANCES   = 6,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Input items
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [SAMPLE_BITS-1:0]  in_tdata,   // [15:0] sample_in
  input  wire logic [2:0]              in_tuser,   // [0] side, [2:1] filter_type
  // Result items
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [SAMPLE_BITS-1:0]       out_tdata,  // [15:0] sample_out
  // Configuration writes
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  // Coefficient registers
  logic [NUM_W-1:0] lp_num_r, hpl_num_r, hph_num_r;
  logic [DEN_W-1:0] lp_den_r, hpl_den_r, hph_den_r;

  // History memory and per-entry valid bits
  logic [HIST_W-1:0]        hist_mem [NUM_INSTANCES];
  logic [NUM_INSTANCES-1:0] hvld_r;

  // Stage 1: history read, products
  logic                   s1_vld_r, s1_hit_r, s1_hvld_r, s1_fwd_r;
  logic [AW-1:0]          s1_addr_r;
  logic [1:0]             s1_type_r;
  logic [SAMPLE_BITS-1:0] s1_x_r;
  logic [HIST_W-1:0]      rd_hist_r, fwd_hist_r;

  // Stage 2: sum, round, saturate, write back
  logic                     s2_vld_r, s2_hit_r;
  logic [AW-1:0]            s2_addr_r;
  logic [SAMPLE_BITS-1:0]   s2_x_r, s2_x1_r, s2_y1_r;
  logic signed [PROD_W-1:0] s2_p0_r, s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r;

  logic                   out_tvalid_r;
  logic [SAMPLE_BITS-1:0] out_tdata_r;

  logic                   adv, accept, conflict, mem_we;
  logic [2:0]             in_idx;
  logic                   in_hit;
  logic [AW-1:0]          in_addr;
  logic [HIST_W-1:0]      s1_hist, wr_hist;
  logic [NUM_W-1:0]       s1_num;
  logic [DEN_W-1:0]       s1_den;
  logic signed [ACC_W-1:0] acc_sum, acc_rnd, acc_sh;
  logic [SAMPLE_BITS-1:0] sat;

  // Configuration writes: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_num_r  <= LP_NUM_RST;
      lp_den_r  <= LP_DEN_RST;
      hpl_num_r <= HPL_NUM_RST;
      hpl_den_r <= HPL_DEN_RST;
      hph_num_r <= HPH_NUM_RST;
      hph_den_r <= HPH_DEN_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LP_NUM:  lp_num_r  <= cfg_data[NUM_W-1:0];
        REG_LP_DEN:  lp_den_r  <= cfg_data[DEN_W-1:0];
        REG_HPL_NUM: hpl_num_r <= cfg_data[NUM_W-1:0];
        REG_HPL_DEN: hpl_den_r <= cfg_data[DEN_W-1:0];
        REG_HPH_NUM: hph_num_r <= cfg_data[NUM_W-1:0];
        REG_HPH_DEN: hph_den_r <= cfg_data[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the instance of the incoming item
  assign in_idx  = {1'b0, in_tuser[2:1]} + (in_tuser[0] ? 3'(TYPES_PER_SIDE) : 3'd0);
  assign in_hit  = (in_tuser[2:1] != FT_UNUSED) && (in_idx < NUM_INSTANCES);
  assign in_addr = AW'(in_idx);

  // Whole pipeline advances while the output register can take a result
  assign adv = !out_tvalid_r || out_tready;

  // Hold an item whose instance is still in stage 1
  assign conflict  = s1_vld_r && s1_hit_r && in_hit && (s1_addr_r == in_addr);
  assign in_tready = adv && !conflict;
  assign accept    = in_tvalid && in_tready;
  assign mem_we    = adv && s2_vld_r && s2_hit_r;

  // Stage 1 capture and history read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r   <= in_hit;
      s1_addr_r  <= in_addr;
      s1_type_r  <= in_tuser[2:1];
      s1_x_r     <= in_tdata;
      rd_hist_r  <= hist_mem[in_addr];
      s1_hvld_r  <= hvld_r[in_addr];
      s1_fwd_r   <= mem_we && (s2_addr_r == in_addr);
      fwd_hist_r <= wr_hist;
    end
  end

  // Pick history: bypass, stored entry, or cleared entry
  always_comb begin
    if (s1_fwd_r) begin
      s1_hist = fwd_hist_r;
    end else if (s1_hvld_r) begin
      s1_hist = rd_hist_r;
    end else begin
      s1_hist = '0;
    end
  end

  // Select the coefficient set of the filter type
  always_comb begin
    case (filter_type_t'(s1_type_r))
      FT_LOWPASS: begin
        s1_num = lp_num_r;
        s1_den = lp_den_r;
      end
      FT_HP_LOW: begin
        s1_num = hpl_num_r;
        s1_den = hpl_den_r;
      end
      FT_HP_HIGH: begin
        s1_num = hph_num_r;
        s1_den = hph_den_r;
      end
      default: begin
        s1_num = '0;
        s1_den = '0;
      end
    endcase
  end

  // Five products in parallel, registered into stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hit_r  <= s1_hit_r;
      s2_addr_r <= s1_addr_r;
      s2_x_r    <= s1_x_r;
      s2_x1_r   <= s1_hist[SAMPLE_BITS-1:0];
      s2_y1_r   <= s1_hist[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      s2_p0_r   <= $signed(s1_num[COEFF_BITS-1:0]) * $signed(s1_x_r);
      s2_p1_r   <= $signed(s1_num[2*COEFF_BITS-1:COEFF_BITS])
                   * $signed(s1_hist[SAMPLE_BITS-1:0]);
      s2_p2_r   <= $signed(s1_num[3*COEFF_BITS-1:2*COEFF_BITS])
                   * $signed(s1_hist[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      s2_p3_r   <= $signed(s1_den[COEFF_BITS-1:0])
                   * $signed(s1_hist[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
      s2_p4_r   <= $signed(s1_den[2*COEFF_BITS-1:COEFF_BITS])
                   * $signed(s1_hist[4*SAMPLE_BITS-1:3*SAMPLE_BITS]);
    end
  end

  // Sum, round half up, shift down, saturate
  always_comb begin
    acc_sum = ACC_W'(s2_p0_r) + ACC_W'(s2_p1_r) + ACC_W'(s2_p2_r)
              - ACC_W'(s2_p3_r) - ACC_W'(s2_p4_r);
    acc_rnd = acc_sum + RND;
    acc_sh  = acc_rnd >>> COEFF_FRAC_BITS;
    if (acc_sh > SMAX) begin
      sat = SMAX[SAMPLE_BITS-1:0];
    end else if (acc_sh < SMIN) begin
      sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sat = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  // Shifted history: {y2 <- y1, y1 <- result, x2 <- x1, x1 <- x}
  assign wr_hist = {s2_y1_r, sat, s2_x1_r, s2_x_r};

  // Write back history
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[s2_addr_r] <= wr_hist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r <= '0;
    end else if (mem_we) begin
      hvld_r[s2_addr_r] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= s2_hit_r ? sat : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Same instance never sits in both stages at once
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_hit_r && s2_vld_r && s2_hit_r) |-> (s1_addr_r != s2_addr_r))
    else $error("same filter instance in stage 1 and stage 2");

  // An item that selects no instance gives a zero result
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r && !s2_hit_r) |=> (out_tdata == '0))
    else $error("unused filter type gave a nonzero result");

  // Reset leaves all history cleared
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (hvld_r == '0))
    else $error("history valid bits set after reset");

  // Bypass only from a write of a hit item
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mem_we && (s2_addr_r == in_addr)) |-> s2_hit_r)
    else $error("bypass taken from a non-writing item");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the biquad IIR filter bank core.
module tb;
  import biquad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS    = 14;
  localparam int NUM_FILTERS  = 2 * TYPES_PER_SIDE;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_SLACK  = 6;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 80;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [COEFF_BITS-1:0]  COEFF_MAX  = 16'h7FFF;
  localparam logic [COEFF_BITS-1:0]  COEFF_MIN  = 16'h8000;
  localparam logic [COEFF_BITS-1:0]  COEFF_NEG1 = 16'hFFFF;

  // Indexes past the register file; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_IDX_PAST = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP  = '1;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   side;
    filter_type_t           ftype;
  } filtered_sample_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [SAMPLE_BITS-1:0]  in_tdata  = '0;  // [15:0] sample_in
  logic [2:0]              in_tuser  = '0;  // [0] side, [2:1] filter_type
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [SAMPLE_BITS-1:0]  out_tdata;       // [15:0] sample_out
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // Shadow copy of the coefficient registers and the per-filter history
  logic [CFG_DATA_W-1:0] coef_shadow [NUM_REGS];
  longint hist_x1 [NUM_FILTERS];
  longint hist_x2 [NUM_FILTERS];
  longint hist_y1 [NUM_FILTERS];
  longint hist_y2 [NUM_FILTERS];

  filtered_sample_t expected_samples [$];

  int  items_sent     = 0;
  int  results_seen   = 0;
  int  reg_writes     = 0;
  int  saturations    = 0;
  int  unused_items   = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  int  sink_hold_req  = 0;
  bit  sender_fast    = 1'b0;
  bit  sink_fast      = 1'b0;

  biquad_iir_filter_bank_core #(
    .NUM_INSTANCES  (NUM_FILTERS),
    .COEFF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_samples.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint coeff_at(input logic [CFG_DATA_W-1:0] r, input int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_num(input logic [15:0] a0,
                                                     input logic [15:0] a1,
                                                     input logic [15:0] a2);
    return {a2, a1, a0};
  endfunction

  // Upper word is junk on purpose: the block keeps only 32 bits
  function automatic logic [CFG_DATA_W-1:0] pack_den(input logic [15:0] b1,
                                                     input logic [15:0] b2);
    return {16'($urandom), b2, b1};
  endfunction

  // Compute the filtered sample for one item and advance the shadow history
  function automatic logic [SAMPLE_BITS-1:0] predict_filtered_sample(
      input logic side, input filter_type_t ft, input logic [SAMPLE_BITS-1:0] xin);
    int unsigned           inst;
    logic [CFG_DATA_W-1:0] num;
    logic [CFG_DATA_W-1:0] den;
    longint                x;
    longint                acc;
    longint                hi;
    longint                lo;
    if (ft == FT_UNUSED) begin
      unused_items++;
      return '0;
    end
    inst = int'(side) * TYPES_PER_SIDE + int'(ft);
    num  = coef_shadow[2 * int'(ft)];
    den  = coef_shadow[2 * int'(ft) + 1];
    x    = longint'($signed(xin));
    hi   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo   = -hi - 1;
    acc  = coeff_at(num, 0) * x
         + coeff_at(num, 1) * hist_x1[inst]
         + coeff_at(num, 2) * hist_x2[inst]
         - coeff_at(den, 0) * hist_y1[inst]
         - coeff_at(den, 1) * hist_y2[inst];
    // Round half up, then clamp to the sample range
    acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (acc > hi || acc < lo) saturations++;
    if (acc > hi) acc = hi;
    if (acc < lo) acc = lo;
    hist_y2[inst] = hist_y1[inst];
    hist_y1[inst] = acc;
    hist_x2[inst] = hist_x1[inst];
    hist_x1[inst] = x;
    return acc[SAMPLE_BITS-1:0];
  endfunction

  // Offer one item after a random gap; keep valid high if no gap follows
  task automatic send_sample(input logic side, input filter_type_t ft,
                             input logic [SAMPLE_BITS-1:0] smp);
    int               gap;
    filtered_sample_t want;
    gap = sender_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {ft, side};
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    want.sample = predict_filtered_sample(side, ft, smp);
    want.side   = side;
    want.ftype  = ft;
    expected_samples.push_back(want);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (idx == REG_LP_DEN || idx == REG_HPL_DEN || idx == REG_HPH_DEN)
      coef_shadow[idx] = {{(CFG_DATA_W-DEN_W){1'b0}}, val[DEN_W-1:0]};
    else if (idx < NUM_REGS)
      coef_shadow[idx] = val;
  endtask

  // Reprogram all six registers while the bank is idle
  task automatic load_coeffs(input logic [CFG_DATA_W-1:0] lp_num,
                             input logic [CFG_DATA_W-1:0] lp_den,
                             input logic [CFG_DATA_W-1:0] hpl_num,
                             input logic [CFG_DATA_W-1:0] hpl_den,
                             input logic [CFG_DATA_W-1:0] hph_num,
                             input logic [CFG_DATA_W-1:0] hph_den);
    drain_results();
    write_reg(REG_LP_NUM,  lp_num);
    write_reg(REG_LP_DEN,  lp_den);
    write_reg(REG_HPL_NUM, hpl_num);
    write_reg(REG_HPL_DEN, hpl_den);
    write_reg(REG_HPH_NUM, hph_num);
    write_reg(REG_HPH_DEN, hph_den);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coeff(input bit tame);
    if (tame) return 16'(int'($urandom_range(0, 8191)) - 4096);
    return 16'($urandom);
  endfunction

  // Bursts to one filter with random content, mixed with scattered items
  task automatic run_bursts(input int n_items);
    int                     sent;
    int                     len;
    int                     mode;
    logic                   side;
    filter_type_t           ft;
    logic [SAMPLE_BITS-1:0] smp;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) sender_fast = ~sender_fast;
      if ($urandom_range(0, 5) == 0) sink_fast = ~sink_fast;
      side = 1'($urandom_range(0, 1));
      ft   = ($urandom_range(0, 9) == 0) ? FT_UNUSED
                                         : filter_type_t'($urandom_range(0, 2));
      len  = $urandom_range(1, 8);
      mode = $urandom_range(0, 3);
      repeat (len) begin
        case (mode)
          0: smp = 16'($urandom);
          1: smp = 16'(int'($urandom_range(0, 2047)) - 1024);
          2: smp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
          default: begin
            side = 1'($urandom_range(0, 1));
            ft   = filter_type_t'($urandom_range(0, 3));
            smp  = 16'($urandom);
          end
        endcase
        send_sample(side, ft, smp);
        sent++;
      end
    end
  endtask

  // Receiver: random stall after each item, plus requested long hold-offs
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        stall         = sink_hold_req;
        sink_hold_req = 0;
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else if (out_tready && out_tvalid) begin
        stall = sink_fast ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_tready <= 1'b1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    filtered_sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result %h at cycle %0d", out_tdata, cycle_count);
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want.sample) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch on result %0d (side %0d, %s): expected %h, got %h",
                     results_seen, want.side, want.ftype.name(), want.sample,
                     out_tdata);
        end
      end
    end
  end

  // Every filter with full-scale samples, and the unused type
  task automatic test_full_scale_steps();
    filter_type_t ft;
    for (int s = 0; s < 2; s++) begin
      for (int t = 0; t < 4; t++) begin
        ft = filter_type_t'(t);
        send_sample(1'(s), ft, SAMPLE_MAX);
        send_sample(1'(s), ft, SAMPLE_MIN);
      end
    end
    send_sample(1'b0, FT_LOWPASS, 16'h0000);
    send_sample(1'b1, FT_HP_HIGH, 16'h0001);
    send_sample(1'b0, FT_UNUSED,  16'h5555);
    send_sample(1'b1, FT_HP_LOW,  16'hFFFF);
    drain_results();
  endtask

  task automatic test_default_stream();
    for (int i = 0; i < 3; i++) begin
      run_bursts(100);
      // Pause the sender until the bank is empty
      drain_results();
    end
  endtask

  // Block the output long enough for the bank to stall its input
  task automatic test_output_backpressure();
    sender_fast   = 1'b1;
    sink_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 40; i++)
      send_sample(1'(i % 2), filter_type_t'((i / 2) % 3), 16'($urandom));
    sender_fast = 1'b0;
    drain_results();
  endtask

  // Extreme coefficients, saturation both ways, and dropped writes
  task automatic test_coeff_extremes();
    load_coeffs(pack_num(COEFF_MAX, COEFF_MAX, COEFF_MAX), pack_den(COEFF_MIN, COEFF_MIN),
                pack_num(COEFF_MIN, COEFF_MIN, COEFF_MIN), pack_den(COEFF_MAX, COEFF_MAX),
                pack_num(COEFF_MAX, COEFF_MIN, COEFF_MAX), pack_den(COEFF_NEG1, COEFF_MIN));
    // Out-of-range indexes must leave the registers alone
    write_reg(REG_IDX_PAST, '1);
    write_reg(REG_IDX_TOP,  '0);
    cfg_valid <= 1'b0;
    @(posedge clk);
    repeat (3) send_sample(1'b0, FT_LOWPASS, SAMPLE_MAX);
    repeat (3) send_sample(1'b0, FT_LOWPASS, SAMPLE_MIN);
    repeat (2) send_sample(1'b1, FT_HP_LOW, SAMPLE_MIN);
    run_bursts(80);

    load_coeffs('0, '0, '0, '0, '0, '0);
    run_bursts(40);

    load_coeffs('1, '1, '1, '1, '1, '1);
    run_bursts(60);

    load_coeffs(pack_num(COEFF_MIN, COEFF_MAX, COEFF_MIN), pack_den(COEFF_MAX, COEFF_MIN),
                pack_num(COEFF_NEG1, COEFF_NEG1, COEFF_NEG1), pack_den(COEFF_NEG1, COEFF_NEG1),
                pack_num(COEFF_MIN, COEFF_MIN, COEFF_MIN), pack_den(COEFF_MIN, COEFF_MAX));
    run_bursts(60);
  endtask

  task automatic test_random_coeffs();
    bit tame;
    for (int p = 0; p < 3; p++) begin
      tame = (p != 0);
      load_coeffs({rand_coeff(tame), rand_coeff(tame), rand_coeff(tame)},
                  pack_den(rand_coeff(tame), rand_coeff(tame)),
                  {rand_coeff(tame), rand_coeff(tame), rand_coeff(tame)},
                  pack_den(rand_coeff(tame), rand_coeff(tame)),
                  {rand_coeff(tame), rand_coeff(tame), rand_coeff(tame)},
                  pack_den(rand_coeff(tame), rand_coeff(tame)));
      run_bursts(150);
    end
  endtask

  task automatic test_restored_defaults();
    load_coeffs(LP_NUM_RST, LP_DEN_RST, HPL_NUM_RST, HPL_DEN_RST, HPH_NUM_RST, HPH_DEN_RST);
    run_bursts(200);
    drain_results();
  endtask

  initial begin : main_seq
    coef_shadow[REG_LP_NUM]  = LP_NUM_RST;
    coef_shadow[REG_LP_DEN]  = LP_DEN_RST;
    coef_shadow[REG_HPL_NUM] = HPL_NUM_RST;
    coef_shadow[REG_HPL_DEN] = HPL_DEN_RST;
    coef_shadow[REG_HPH_NUM] = HPH_NUM_RST;
    coef_shadow[REG_HPH_DEN] = HPH_DEN_RST;
    for (int i = 0; i < NUM_FILTERS; i++) begin
      hist_x1[i] = 0;
      hist_x2[i] = 0;
      hist_y1[i] = 0;
      hist_y2[i] = 0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_scale_steps();
    test_default_stream();
    test_output_backpressure();
    test_coeff_extremes();
    test_random_coeffs();
    test_restored_defaults();

    if (expected_samples.size() != 0) begin
      mismatches += expected_samples.size();
      $display("%0d results never arrived", expected_samples.size());
    end
    $display("Filtered %0d items (%0d unused type, %0d saturated) over %0d register writes",
             items_sent, unused_items, saturations, reg_writes);
    $display("Checked %0d results in %0d cycles, %0d failures",
             results_seen, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
